// File: hw/rtl/tsvc_pkg.sv
// ----------------------------------------------------------------------------
// tsvc_pkg
// shared types, constants and letter arithmetic for the vertical two-square
// cipher core
// ----------------------------------------------------------------------------
package tsvc_pkg;

    localparam int LW      = 5;
    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    localparam logic [LW-1:0] LETTER_I   = 5'd8;
    localparam logic [LW-1:0] LETTER_J   = 5'd9;
    localparam logic [LW-1:0] LETTER_X   = 5'd23;
    localparam logic [LW-1:0] LETTER_Z   = 5'd25;
    localparam logic [LW-1:0] SPACE_CODE = 5'd26;

    localparam logic [1:0] KIND_KEY = 2'd0;
    localparam logic [1:0] KIND_ENC = 2'd1;
    localparam logic [1:0] KIND_DEC = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POS,
        ST_SQ
    } t_pair_state;

    typedef enum logic {
        KS_IDLE,
        KS_FILL
    } t_key_state;

    typedef struct packed {
        logic          we;
        logic [LW-1:0] slot;
        logic [LW-1:0] letter;
    } t_key_wr;

    typedef struct packed {
        logic complete;
        logic busy;
    } t_key_status;

    function automatic logic [LW-1:0] clean_letter(input logic [LW-1:0] v);
        logic [LW-1:0] l;
        l = (v > LETTER_Z) ? LETTER_Z : v;
        if (l == LETTER_J) begin
            l = LETTER_I;
        end
        return l;
    endfunction

    function automatic logic [LW-1:0] plain_position(input logic [LW-1:0] l);
        return (l < LETTER_J) ? l : l - 5'd1;
    endfunction

    function automatic logic [LW-1:0] plain_letter(input logic [LW-1:0] p);
        return (p < LETTER_J) ? p : p + 5'd1;
    endfunction

    function automatic logic [2:0] pos_row(input logic [LW-1:0] p);
        logic [2:0] r;
        if (p >= 5'd30) begin
            r = 3'd6;
        end else if (p >= 5'd25) begin
            r = 3'd5;
        end else if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [LW-1:0] p);
        logic [LW:0] base;
        logic [LW:0] diff;
        base = 6'(pos_row(p)) * 6'(SIDE);
        diff = {1'b0, p} - base;
        return diff[2:0];
    endfunction

    function automatic logic [LW-1:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        logic [LW+1:0] s;
        s = 7'(row) * 7'(SIDE) + 7'(col);
        return s[LW-1:0];
    endfunction

endpackage

// File: hw/rtl/tsvc_ram.sv
// ----------------------------------------------------------------------------
// tsvc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tsvc_ram #(
    parameter int  WIDTH = 5,
    parameter int  DEPTH = 25,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/tsvc_key_loader.sv
// ----------------------------------------------------------------------------
// tsvc_key_loader
// places key letters into the keyed square and scans the alphabet to fill
// the remaining cells after the last key letter
// ----------------------------------------------------------------------------
module tsvc_key_loader (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [tsvc_pkg::LW-1:0] i_letter,
    input  logic                  i_last,
    output tsvc_pkg::t_key_wr     o_wr,
    output tsvc_pkg::t_key_status o_status
);

    tsvc_pkg::t_key_state r_state, n_state;
    logic [tsvc_pkg::LETTERS-1:0] r_seen, n_seen;
    logic [tsvc_pkg::LW-1:0]      r_fill, n_fill;
    logic [tsvc_pkg::LW-1:0]      r_scan, n_scan;
    logic                         r_complete, n_complete;
    logic                         r_loading, n_loading;

    logic                         w_filling;
    logic [tsvc_pkg::LETTERS-1:0] w_seen_eff;
    logic [tsvc_pkg::LW-1:0]      w_fill_eff;
    logic [tsvc_pkg::LW-1:0]      w_cand;
    logic                         w_place;

    always_comb begin
        case (r_state)
            tsvc_pkg::KS_IDLE: n_state = (i_go && i_last) ? tsvc_pkg::KS_FILL
                                                           : tsvc_pkg::KS_IDLE;
            tsvc_pkg::KS_FILL: n_state = (r_scan == tsvc_pkg::LETTER_Z) ? tsvc_pkg::KS_IDLE
                                                                          : tsvc_pkg::KS_FILL;
            default:           n_state = tsvc_pkg::KS_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            tsvc_pkg::KS_FILL: w_filling = 1'b1;
            default:           w_filling = 1'b0;
        endcase
    end

    // a key letter outside a load starts a fresh square
    assign w_seen_eff = r_loading ? r_seen : '0;
    assign w_fill_eff = r_loading ? r_fill : '0;
    assign w_cand     = w_filling ? r_scan : i_letter;
    assign w_place    = (w_filling || i_go) && (w_cand != tsvc_pkg::LETTER_J)
                        && !w_seen_eff[w_cand]
                        && (w_fill_eff < 5'(tsvc_pkg::CELLS));

    always_comb begin
        n_seen     = r_seen;
        n_fill     = r_fill;
        n_scan     = r_scan;
        n_complete = r_complete;
        n_loading  = r_loading;
        if (i_go || w_filling) begin
            n_seen = w_seen_eff | (w_place ? (26'd1 << w_cand) : '0);
            n_fill = w_fill_eff + (w_place ? 5'd1 : 5'd0);
        end
        if (i_go && !w_filling) begin
            n_loading = 1'b1;
            n_scan    = '0;
            if (!r_loading) begin
                n_complete = 1'b0;
            end
        end
        if (w_filling) begin
            n_scan = r_scan + 5'd1;
            if (r_scan == tsvc_pkg::LETTER_Z) begin
                n_complete = 1'b1;
                n_loading  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tsvc_pkg::KS_IDLE;
            r_seen     <= '0;
            r_fill     <= '0;
            r_scan     <= '0;
            r_complete <= 1'b0;
            r_loading  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_seen     <= n_seen;
            r_fill     <= n_fill;
            r_scan     <= n_scan;
            r_complete <= n_complete;
            r_loading  <= n_loading;
        end
    end

    assign o_wr.we           = w_place;
    assign o_wr.slot         = w_fill_eff;
    assign o_wr.letter       = w_cand;
    assign o_status.complete = r_complete;
    assign o_status.busy     = w_filling;

endmodule

// File: hw/rtl/two_square_vertical_cipher_core.sv
// per pair: position ram read, then square ram read, then registered output
// a new pair can be accepted in the square state when the output is free
// the last key letter starts an alphabet scan, during which no item is accepted
// reset clears control state and the letter-seen flags; the rams are not cleared
// ----------------------------------------------------------------------------
// two_square_vertical_cipher_core
// vertical two-square cipher with keyed right square held in two rams
// ----------------------------------------------------------------------------
module two_square_vertical_cipher_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_kind,
    input  logic [tsvc_pkg::LW-1:0] i_first_letter,
    input  logic [tsvc_pkg::LW-1:0] i_second_letter,
    input  logic                    i_last,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [tsvc_pkg::LW-1:0] o_out_first,
    output logic [tsvc_pkg::LW-1:0] o_out_second,
    output logic                    o_no_key
);

    tsvc_pkg::t_pair_state r_state, n_state;
    tsvc_pkg::t_key_wr     w_wr;
    tsvc_pkg::t_key_status w_key;

    logic [tsvc_pkg::LW-1:0] w_a, w_b, w_b_eff;
    logic w_accept, w_key_go, w_pair_go, w_out_free, w_out_load, w_in_ready, w_hold_sq;

    logic [tsvc_pkg::LW-1:0] r_a, r_b, r_r1, r_sq_addr;
    logic r_dec, r_last, r_nokey, r_same;

    logic [tsvc_pkg::LW-1:0] w_pos_rdata, w_sq_rdata, w_sq_raddr;
    logic [tsvc_pkg::LW-1:0] w_pa, w_calc_addr, w_r1, w_r2;
    logic [2:0] w_ra, w_ca, w_rb, w_cb;

    logic r_out_valid;
    logic [tsvc_pkg::LW-1:0] r_out_first, r_out_second;
    logic r_no_key;

    assign w_a        = tsvc_pkg::clean_letter(i_first_letter);
    assign w_b        = tsvc_pkg::clean_letter(i_second_letter);
    assign w_b_eff    = (i_kind == tsvc_pkg::KIND_ENC && w_a == w_b) ? tsvc_pkg::LETTER_X : w_b;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && w_in_ready;
    assign w_key_go   = w_accept && (i_kind == tsvc_pkg::KIND_KEY);
    assign w_pair_go  = w_accept && (i_kind == tsvc_pkg::KIND_ENC || i_kind == tsvc_pkg::KIND_DEC);

    // next state
    always_comb begin
        case (r_state)
            tsvc_pkg::ST_IDLE: n_state = w_pair_go ? tsvc_pkg::ST_POS : tsvc_pkg::ST_IDLE;
            tsvc_pkg::ST_POS:  n_state = tsvc_pkg::ST_SQ;
            tsvc_pkg::ST_SQ: begin
                if (!w_out_free) begin
                    n_state = tsvc_pkg::ST_SQ;
                end else if (w_pair_go) begin
                    n_state = tsvc_pkg::ST_POS;
                end else begin
                    n_state = tsvc_pkg::ST_IDLE;
                end
            end
            default: n_state = tsvc_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        case (r_state)
            tsvc_pkg::ST_IDLE: begin
                w_in_ready = !w_key.busy;
                w_out_load = 1'b0;
                w_hold_sq  = 1'b0;
            end
            tsvc_pkg::ST_SQ: begin
                w_in_ready = w_out_free;
                w_out_load = w_out_free;
                w_hold_sq  = 1'b1;
            end
            default: begin
                w_in_ready = 1'b0;
                w_out_load = 1'b0;
                w_hold_sq  = 1'b0;
            end
        endcase
    end

    tsvc_key_loader u_key_loader (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_key_go),
        .i_letter (w_a),
        .i_last   (i_last),
        .o_wr     (w_wr),
        .o_status (w_key)
    );

    // keyed square: cell -> letter
    tsvc_ram #(
        .WIDTH (tsvc_pkg::LW),
        .DEPTH (tsvc_pkg::CELLS)
    ) u_square_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.slot),
        .i_wdata (w_wr.letter),
        .i_raddr (w_sq_raddr),
        .o_rdata (w_sq_rdata)
    );

    // keyed position: letter -> cell
    tsvc_ram #(
        .WIDTH (tsvc_pkg::LW),
        .DEPTH (tsvc_pkg::LETTERS)
    ) u_position_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.letter),
        .i_wdata (w_wr.slot),
        .i_raddr (w_b_eff),
        .o_rdata (w_pos_rdata)
    );

    // position stage
    assign w_pa        = tsvc_pkg::plain_position(r_a);
    assign w_ra        = tsvc_pkg::pos_row(w_pa);
    assign w_ca        = tsvc_pkg::pos_col(w_pa);
    assign w_rb        = tsvc_pkg::pos_row(w_pos_rdata);
    assign w_cb        = tsvc_pkg::pos_col(w_pos_rdata);
    assign w_calc_addr = tsvc_pkg::cell_of(w_rb, w_ca);
    assign w_sq_raddr  = w_hold_sq ? r_sq_addr : w_calc_addr;

    // square stage
    always_comb begin
        w_r1 = r_r1;
        w_r2 = r_same ? r_b : w_sq_rdata;
        if (r_dec && w_r2 == tsvc_pkg::LETTER_X) begin
            w_r2 = r_last ? tsvc_pkg::SPACE_CODE : w_r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pair_go) begin
            r_a     <= w_a;
            r_b     <= w_b_eff;
            r_dec   <= (i_kind == tsvc_pkg::KIND_DEC);
            r_last  <= i_last;
            r_nokey <= !w_key.complete;
        end
        if (r_state == tsvc_pkg::ST_POS) begin
            r_same    <= (w_ca == w_cb);
            r_r1      <= (w_ca == w_cb) ? r_a
                         : tsvc_pkg::plain_letter(tsvc_pkg::cell_of(w_ra, w_cb));
            r_sq_addr <= w_calc_addr;
        end
        if (w_out_load) begin
            r_out_first  <= r_nokey ? '0 : w_r1;
            r_out_second <= r_nokey ? '0 : w_r2;
            r_no_key     <= r_nokey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsvc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_out_load | (r_out_valid & ~i_out_ready);
        end
    end

    assign o_in_ready   = w_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_first  = r_out_first;
    assign o_out_second = r_out_second;
    assign o_no_key     = r_no_key;

    a_pos_then_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tsvc_pkg::ST_POS |=> r_state == tsvc_pkg::ST_SQ)
        else $error("position stage not followed by square stage");

    a_fill_sets_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_key.busy) |-> w_key.complete)
        else $error("alphabet scan ended without a complete key");

    a_no_accept_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key.busy |-> !w_accept && r_state == tsvc_pkg::ST_IDLE)
        else $error("item accepted during key scan");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_first <= tsvc_pkg::LETTER_Z
                        && o_out_second <= tsvc_pkg::SPACE_CODE)
        else $error("result letter out of range");

endmodule
